>>> rtl/nnts_pkg.sv
// shared types, widths and codes of the nearest neighbor texture scaler
package nnts_pkg;

    // fixed field widths
    localparam int COORD_W = 10;
    localparam int SRC_W   = 7;
    localparam int DSP_W   = 11;
    localparam int FMT_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int TEXEL_W = 4 * BYTE_W;
    localparam int ARGB_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DSP_W;

    // divider sizing: quotient never exceeds the source side
    localparam int QUOT_W = SRC_W;
    localparam int NUM_W  = COORD_W + SRC_W + 1;
    localparam int DSH_W  = DSP_W + QUOT_W - 1;
    localparam int STEP_W = $clog2(QUOT_W);

    // parameter defaults
    localparam int MAX_SOURCE_SIDE_DEF  = 64;
    localparam int MAX_DISPLAY_SIDE_DEF = 1024;

    // register reset values
    localparam logic [SRC_W-1:0] SRC_W_RST = SRC_W'(64);
    localparam logic [SRC_W-1:0] SRC_H_RST = SRC_W'(64);
    localparam logic [DSP_W-1:0] DSP_W_RST = DSP_W'(64);
    localparam logic [DSP_W-1:0] DSP_H_RST = DSP_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH   = 3'd0,
        CFG_SOURCE_HEIGHT  = 3'd1,
        CFG_DISPLAY_WIDTH  = 3'd2,
        CFG_DISPLAY_HEIGHT = 3'd3,
        CFG_PIXEL_FORMAT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_GRAY = 2'd0,
        FMT_RGB  = 2'd1,
        FMT_RGBA = 2'd2
    } fmt_t;

    localparam logic [FMT_W-1:0] FMT_RST = FMT_RGB;

    typedef enum logic [0:0] {
        MODE_WRITE = 1'b0,
        MODE_READ  = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_S,
        ST_DIV_T,
        ST_MEM,
        ST_MUL,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic mem_wr;
        logic div_start;
        logic div_sel_t;
        logic cap_s;
        logic cap_t;
        logic mem_rd;
        logic mul_en;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic outside;
        logic write_ok;
        logic div_done;
    } status_t;

endpackage

>>> rtl/nnts_if.sv
// item channel interfaces of the texture scaler
interface nnts_in_if
    import nnts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [BYTE_W-1:0]  byte_zero;
    logic [BYTE_W-1:0]  byte_one;
    logic [BYTE_W-1:0]  byte_two;
    logic [BYTE_W-1:0]  byte_three;

    modport source (
        output valid, mode, coord_x, coord_y, byte_zero, byte_one, byte_two, byte_three,
        input  ready
    );
    modport sink (
        input  valid, mode, coord_x, coord_y, byte_zero, byte_one, byte_two, byte_three,
        output ready
    );
endinterface

interface nnts_out_if
    import nnts_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ARGB_W-1:0] argb;
    logic              drawn;

    modport source (
        output valid, argb, drawn,
        input  ready
    );
    modport sink (
        input  valid, argb, drawn,
        output ready
    );
endinterface

>>> rtl/nearest_neighbor_texture_scaler.sv
// top level of the nearest neighbor texture scaler
//
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+-----------
//  in_ch    | in  | mode, coord_x, coord_y, byte_zero..byte_three   | valid/ready
//  out_ch   | out | argb, drawn (one item per read, none per write) | valid/ready
//  cfg      | in  | cfg_we, cfg_index, cfg_wdata                    | write enable
//
// one item at a time; a pixel inside the display goes through the shared restoring
// divider (7 steps for s, 7 for t), the registered texel store read and the alpha
// multiply stage, while a texel write or a pixel outside the display skips them
// reset returns the controller and the configuration registers to their reset values; the store is not cleared
// a finished result waits in the output register while the next item is taken in;
// a new result only waits if the previous one has not yet been taken
module nearest_neighbor_texture_scaler
    import nnts_pkg::*;
#(
    parameter int MAX_SOURCE_SIDE  = MAX_SOURCE_SIDE_DEF,
    parameter int MAX_DISPLAY_SIDE = MAX_DISPLAY_SIDE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    nnts_in_if.sink               in_ch,
    nnts_out_if.source            out_ch
);

    // command and status between the state machine and the datapath
    cmd_t    cmd;
    status_t st;

    // sequencing: accept, decode, divide twice, read store, multiply, deliver
    nnts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // mapping arithmetic, texel store and color expansion
    nnts_dp #(
        .MAX_SOURCE_SIDE  (MAX_SOURCE_SIDE),
        .MAX_DISPLAY_SIDE (MAX_DISPLAY_SIDE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mode       (in_ch.mode),
        .coord_x    (in_ch.coord_x),
        .coord_y    (in_ch.coord_y),
        .byte_zero  (in_ch.byte_zero),
        .byte_one   (in_ch.byte_one),
        .byte_two   (in_ch.byte_two),
        .byte_three (in_ch.byte_three),
        .cmd        (cmd),
        .st         (st),
        .argb       (out_ch.argb),
        .drawn      (out_ch.drawn)
    );

endmodule

>>> rtl/nnts_div.sv
// restoring divider, one quotient bit per cycle
module nnts_div
    import nnts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DSP_W-1:0]  denom,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              ge;

    assign ge = rem_reg >= NUM_W'(dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (!busy_reg && start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && step_reg == '0)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            rem_reg  <= numer;
            dsh_reg  <= {denom, {(QUOT_W-1){1'b0}}};
            step_reg <= STEP_W'(QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> rtl/nnts_ctrl.sv
// controller state machine of the texture scaler
module nnts_ctrl
    import nnts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!st.is_read)
                begin
                    cmd.mem_wr = st.write_ok;
                    state_next = ST_IDLE;
                end
                else if (st.outside)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_S;
                end
            end
            ST_DIV_S:
            begin
                if (st.div_done)
                begin
                    cmd.cap_s     = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_t = 1'b1;
                    state_next    = ST_DIV_T;
                end
            end
            ST_DIV_T:
            begin
                if (st.div_done)
                begin
                    cmd.cap_t  = 1'b1;
                    state_next = ST_MEM;
                end
            end
            ST_MEM:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/nnts_dp.sv
// datapath of the texture scaler: registers, texel store, mapping and color expansion
module nnts_dp
    import nnts_pkg::*;
#(
    parameter int MAX_SOURCE_SIDE  = MAX_SOURCE_SIDE_DEF,
    parameter int MAX_DISPLAY_SIDE = MAX_DISPLAY_SIDE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  mode,
    input  logic [COORD_W-1:0]    coord_x,
    input  logic [COORD_W-1:0]    coord_y,
    input  logic [BYTE_W-1:0]     byte_zero,
    input  logic [BYTE_W-1:0]     byte_one,
    input  logic [BYTE_W-1:0]     byte_two,
    input  logic [BYTE_W-1:0]     byte_three,
    input  cmd_t                  cmd,
    output status_t               st,
    output logic [ARGB_W-1:0]     argb,
    output logic                  drawn
);

    localparam int DEPTH  = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * BYTE_W;

    // configuration registers
    logic [SRC_W-1:0] src_w_reg, src_h_reg;
    logic [DSP_W-1:0] dsp_w_reg, dsp_h_reg;
    logic [FMT_W-1:0] fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SRC_W_RST;
            src_h_reg <= SRC_H_RST;
            dsp_w_reg <= DSP_W_RST;
            dsp_h_reg <= DSP_H_RST;
            fmt_reg   <= FMT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:   src_w_reg <= cfg_wdata[SRC_W-1:0];
                CFG_SOURCE_HEIGHT:  src_h_reg <= cfg_wdata[SRC_W-1:0];
                CFG_DISPLAY_WIDTH:  dsp_w_reg <= cfg_wdata;
                CFG_DISPLAY_HEIGHT: dsp_h_reg <= cfg_wdata;
                CFG_PIXEL_FORMAT:   fmt_reg   <= cfg_wdata[FMT_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize acts as the maximum
    logic [SRC_W-1:0] sw, sh;
    logic [DSP_W-1:0] dw, dh;

    always_comb
    begin
        sw = (src_w_reg == '0) ? SRC_W'(1) :
             (32'(src_w_reg) > MAX_SOURCE_SIDE) ? SRC_W'(MAX_SOURCE_SIDE) : src_w_reg;
        sh = (src_h_reg == '0) ? SRC_W'(1) :
             (32'(src_h_reg) > MAX_SOURCE_SIDE) ? SRC_W'(MAX_SOURCE_SIDE) : src_h_reg;
        dw = (dsp_w_reg == '0) ? DSP_W'(1) :
             (32'(dsp_w_reg) > MAX_DISPLAY_SIDE) ? DSP_W'(MAX_DISPLAY_SIDE) : dsp_w_reg;
        dh = (dsp_h_reg == '0) ? DSP_W'(1) :
             (32'(dsp_h_reg) > MAX_DISPLAY_SIDE) ? DSP_W'(MAX_DISPLAY_SIDE) : dsp_h_reg;
    end

    // input item registers
    logic               mode_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [TEXEL_W-1:0] wdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg  <= mode;
            x_reg     <= coord_x;
            y_reg     <= coord_y;
            wdata_reg <= {byte_three, byte_two, byte_one, byte_zero};
        end
    end

    // division operands: s uses x*sw/dw, t uses ceil((y+1)*sh/dh)
    logic [NUM_W-1:0]  numer;
    logic [DSP_W-1:0]  denom;
    logic              div_done;
    logic [QUOT_W-1:0] quot;

    always_comb
    begin
        if (cmd.div_sel_t)
        begin
            numer = NUM_W'((NUM_W'(y_reg) + NUM_W'(1)) * NUM_W'(sh))
                  + NUM_W'(dh) - NUM_W'(1);
            denom = dh;
        end
        else
        begin
            numer = NUM_W'(NUM_W'(x_reg) * NUM_W'(sw));
            denom = dw;
        end
    end

    nnts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (numer),
        .denom (denom),
        .done  (div_done),
        .quot  (quot)
    );

    logic [SRC_W-1:0] s_reg, t_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_s)
        begin
            s_reg <= quot;
        end
        if (cmd.cap_t)
        begin
            t_reg <= sh - quot;
        end
    end

    // texel store
    logic [TEXEL_W-1:0] store_mem [DEPTH];
    logic [TEXEL_W-1:0] texel_reg;
    logic [ADDR_W-1:0]  waddr, raddr;

    assign waddr = ADDR_W'(32'(y_reg) * MAX_SOURCE_SIDE + 32'(x_reg));
    assign raddr = ADDR_W'(32'(t_reg) * MAX_SOURCE_SIDE + 32'(s_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            store_mem[waddr] <= wdata_reg;
        end
        if (cmd.mem_rd)
        begin
            texel_reg <= store_mem[raddr];
        end
    end

    // alpha products
    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_r_reg <= texel_reg[7:0]   * texel_reg[31:24];
            prod_g_reg <= texel_reg[15:8]  * texel_reg[31:24];
            prod_b_reg <= texel_reg[23:16] * texel_reg[31:24];
        end
    end

    // floor(p/255) for 16-bit p
    function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] acc;
        acc = {1'b0, p} + {1'b0, (p >> BYTE_W)} + (PROD_W+1)'(1);
        return acc[PROD_W-1:BYTE_W];
    endfunction

    logic [BYTE_W-1:0] r, g, b;

    always_comb
    begin
        case (fmt_reg)
            FMT_GRAY:
            begin
                r = texel_reg[7:0];
                g = texel_reg[7:0];
                b = texel_reg[7:0];
            end
            FMT_RGBA:
            begin
                r = div255(prod_r_reg);
                g = div255(prod_g_reg);
                b = div255(prod_b_reg);
            end
            default:
            begin
                r = texel_reg[7:0];
                g = texel_reg[15:8];
                b = texel_reg[23:16];
            end
        endcase
    end

    // result registers
    logic [ARGB_W-1:0] argb_reg;
    logic              drawn_reg;
    logic              outside;

    assign outside = (DSP_W'(x_reg) >= dw) || (DSP_W'(y_reg) >= dh);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            drawn_reg <= !outside;
            argb_reg  <= outside ? '0 : {8'hFF, r, g, b};
        end
    end

    assign st.is_read  = (mode_reg == MODE_READ);
    assign st.outside  = outside;
    assign st.write_ok = (32'(x_reg) < 32'(sw)) && (32'(y_reg) < 32'(sh));
    assign st.div_done = div_done;

    assign argb  = argb_reg;
    assign drawn = drawn_reg;

endmodule

>>> test/tb_top.sv
// testbench of the nearest neighbor texture scaler: pixel scoreboard and top module
import nnts_pkg::*;

typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TEXEL_W-1:0] texel;
} scaler_item_t;

typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic              drawn;
} pixel_t;

class scaler_scoreboard;
    logic [TEXEL_W-1:0] texels  [MAX_SOURCE_SIDE_DEF*MAX_SOURCE_SIDE_DEF];
    bit                 written [MAX_SOURCE_SIDE_DEF*MAX_SOURCE_SIDE_DEF];
    logic [SRC_W-1:0]   src_w_reg = SRC_W_RST;
    logic [SRC_W-1:0]   src_h_reg = SRC_H_RST;
    logic [DSP_W-1:0]   dsp_w_reg = DSP_W_RST;
    logic [DSP_W-1:0]   dsp_h_reg = DSP_H_RST;
    logic [FMT_W-1:0]   fmt_reg   = FMT_RST;
    pixel_t             pending_pixels [$];
    int unsigned        checked = 0;
    int unsigned        errors  = 0;

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_SOURCE_WIDTH:   src_w_reg = value[SRC_W-1:0];
            CFG_SOURCE_HEIGHT:  src_h_reg = value[SRC_W-1:0];
            CFG_DISPLAY_WIDTH:  dsp_w_reg = value[DSP_W-1:0];
            CFG_DISPLAY_HEIGHT: dsp_h_reg = value[DSP_W-1:0];
            CFG_PIXEL_FORMAT:   fmt_reg   = value[FMT_W-1:0];
            default: ;
        endcase
    endfunction

    // zero acts as one, oversize as the maximum
    static function int unsigned clamp_side(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function int unsigned source_width();
        return clamp_side(src_w_reg, MAX_SOURCE_SIDE_DEF);
    endfunction

    function int unsigned source_height();
        return clamp_side(src_h_reg, MAX_SOURCE_SIDE_DEF);
    endfunction

    function int unsigned display_width();
        return clamp_side(dsp_w_reg, MAX_DISPLAY_SIDE_DEF);
    endfunction

    function int unsigned display_height();
        return clamp_side(dsp_h_reg, MAX_DISPLAY_SIDE_DEF);
    endfunction

    // nearest texel of a display pixel, image flipped vertically
    function bit map_pixel(int unsigned x, int unsigned y, output int unsigned idx);
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned s;
        int unsigned t;
        int unsigned up;
        sw  = source_width();
        sh  = source_height();
        dw  = display_width();
        dh  = display_height();
        idx = 0;
        if (x >= dw || y >= dh) return 1'b0;
        s  = (x * sw) / dw;
        up = ((y + 1) * sh + dh - 1) / dh;
        t  = (up <= sh) ? sh - up : 0;
        if (s >= sw) s = sw - 1;
        if (t >= sh) t = sh - 1;
        idx = t * MAX_SOURCE_SIDE_DEF + s;
        return 1'b1;
    endfunction

    function logic [ARGB_W-1:0] shade(logic [TEXEL_W-1:0] texel);
        int unsigned c0;
        int unsigned c1;
        int unsigned c2;
        int unsigned a;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] b;
        c0 = texel[7:0];
        c1 = texel[15:8];
        c2 = texel[23:16];
        a  = texel[31:24];
        case (fmt_reg)
            FMT_GRAY:
            begin
                r = c0[7:0];
                g = c0[7:0];
                b = c0[7:0];
            end
            FMT_RGBA:
            begin
                r = BYTE_W'((c0 * a) / 255);
                g = BYTE_W'((c1 * a) / 255);
                b = BYTE_W'((c2 * a) / 255);
            end
            default:
            begin
                r = c0[7:0];
                g = c1[7:0];
                b = c2[7:0];
            end
        endcase
        return {8'hFF, r, g, b};
    endfunction

    // inside pixel whose texel was never written
    function bit texel_missing(int unsigned x, int unsigned y, output int unsigned idx);
        return map_pixel(x, y, idx) && !written[idx];
    endfunction

    function void note_item(scaler_item_t item);
        int unsigned idx;
        pixel_t      want;
        if (item.mode == MODE_WRITE)
        begin
            if (item.x < source_width() && item.y < source_height())
            begin
                idx          = item.y * MAX_SOURCE_SIDE_DEF + item.x;
                texels[idx]  = item.texel;
                written[idx] = 1'b1;
            end
            return;
        end
        want.drawn = map_pixel(item.x, item.y, idx);
        want.argb  = want.drawn ? shade(texels[idx]) : '0;
        pending_pixels.push_back(want);
    endfunction

    function void check_pixel(logic [ARGB_W-1:0] argb, logic drawn);
        pixel_t want;
        checked++;
        if (pending_pixels.size() == 0)
        begin
            $error("unexpected pixel: argb %h drawn %b", argb, drawn);
            errors++;
            return;
        end
        want = pending_pixels.pop_front();
        if (argb !== want.argb)
        begin
            $error("argb mismatch: expected %h, actual %h", want.argb, argb);
            errors++;
        end
        if (drawn !== want.drawn)
        begin
            $error("drawn mismatch: expected %b, actual %b", want.drawn, drawn);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // wait after the last pixel when draining, well past the time a pixel inside the display takes
    localparam int unsigned SETTLE_CYCLES    = 40;
    localparam int unsigned CYCLE_LIMIT      = 2_000_000;
    // the one long receiver hold-off, after this many pixels
    localparam int unsigned LONG_HOLD_AT     = 300;
    localparam int unsigned LONG_HOLD_CYCLES = 600;
    localparam int unsigned COORD_MAX        = 2**COORD_W - 1;
    // index past the register file, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    // spare format code, behaves as rgb
    localparam logic [FMT_W-1:0]     FMT_SPARE        = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    nnts_in_if  in_ch();
    nnts_out_if out_ch();

    scaler_scoreboard sb = new();

    // percentage of items preceded by a gap on the sending side
    int unsigned send_busy = 0;

    nearest_neighbor_texture_scaler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // idle level: none, light or heavy
    function automatic int unsigned pick_busy();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(int unsigned busy_pct);
        if ($urandom_range(0, 99) >= busy_pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // bias bytes toward the extremes so alpha 0 and 255 show up often
    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [TEXEL_W-1:0] random_texel();
        return {random_byte(), random_byte(), random_byte(), random_byte()};
    endfunction

    // size register values: mostly legal, some zero, some above the maximum
    function automatic int unsigned pick_side(int unsigned maxv, int unsigned field_max);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(maxv + 1, field_max);
            default: return $urandom_range(1, maxv);
        endcase
    endfunction

    // write enable pulse, always with the enable low again between writes
    task automatic write_register(logic [CFG_IDX_W-1:0] index, int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_register(index, CFG_DATA_W'(value));
    endtask

    // offer one item, keep valid high until the handshake
    task automatic send_item(scaler_item_t item);
        int unsigned gap;
        gap = pick_gap(send_busy);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= item.mode;
        in_ch.coord_x    <= item.x;
        in_ch.coord_y    <= item.y;
        in_ch.byte_zero  <= item.texel[7:0];
        in_ch.byte_one   <= item.texel[15:8];
        in_ch.byte_two   <= item.texel[23:16];
        in_ch.byte_three <= item.texel[31:24];
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_item(item);
    endtask

    task automatic put_texel(int unsigned x, int unsigned y, logic [TEXEL_W-1:0] texel);
        scaler_item_t item;
        item.mode  = MODE_WRITE;
        item.x     = COORD_W'(x);
        item.y     = COORD_W'(y);
        item.texel = texel;
        send_item(item);
    endtask

    // a pixel whose texel is still unwritten gets that texel written first
    task automatic read_pixel(int unsigned x, int unsigned y);
        int unsigned  idx;
        scaler_item_t item;
        if (sb.texel_missing(x, y, idx))
            put_texel(idx % MAX_SOURCE_SIDE_DEF, idx / MAX_SOURCE_SIDE_DEF, random_texel());
        item.mode  = MODE_READ;
        item.x     = COORD_W'(x);
        item.y     = COORD_W'(y);
        item.texel = random_texel();
        send_item(item);
    endtask

    // random mix: mostly in-range reads and writes, some anywhere in the coordinate space
    task automatic run_random(int unsigned count);
        int unsigned pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 64 == 0) send_busy = pick_busy();
            pick = $urandom_range(0, 99);
            if (pick < 45)
                read_pixel($urandom_range(0, sb.display_width() - 1),
                           $urandom_range(0, sb.display_height() - 1));
            else if (pick < 75)
                put_texel($urandom_range(0, sb.source_width() - 1),
                          $urandom_range(0, sb.source_height() - 1), random_texel());
            else if (pick < 85)
                put_texel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          random_texel());
            else
                read_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        end
    endtask

    // drop valid, wait for every pixel, then let a trailing write finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                               int unsigned dh, logic [FMT_W-1:0] fmt);
        write_register(CFG_SOURCE_WIDTH, sw);
        write_register(CFG_SOURCE_HEIGHT, sh);
        write_register(CFG_DISPLAY_WIDTH, dw);
        write_register(CFG_DISPLAY_HEIGHT, dh);
        write_register(CFG_PIXEL_FORMAT, fmt);
    endtask

    task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh, logic [FMT_W-1:0] fmt, int unsigned count);
        write_sizes(sw, sh, dw, dh, fmt);
        run_random(count);
        settle();
    endtask

    // pixel receiver: checks every handshake, stalls at random, one long hold-off
    initial
    begin : pixel_sink
        int unsigned stall_left;
        int unsigned busy_pct;
        int unsigned regime_left;
        bit          long_hold_done;
        stall_left     = 0;
        busy_pct       = 0;
        regime_left    = 0;
        long_hold_done = 1'b0;
        out_ch.ready  <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_pixel(out_ch.argb, out_ch.drawn);
            // change the stall level whenever the regime count runs out
            if (regime_left == 0)
            begin
                regime_left = 256;
                busy_pct    = pick_busy();
            end
            regime_left--;
            // block fills up and stalls the sender during this hold
            if (!long_hold_done && sb.checked >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES;
            end
            else if (stall_left == 0)
            begin
                stall_left = pick_gap(busy_pct);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // hard stop if the block hangs
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_SOURCE_WIDTH;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_WRITE;
        in_ch.coord_x    <= '0;
        in_ch.coord_y    <= '0;
        in_ch.byte_zero  <= '0;
        in_ch.byte_one   <= '0;
        in_ch.byte_two   <= '0;
        in_ch.byte_three <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: 64x64 texels onto 64x64 pixels, rgb,
        // so pixel (x, y) reads texel (x, 63-y)
        // corner texels with extreme bytes
        put_texel(0, 0, 32'hFFFF_FFFF);
        put_texel(63, 63, 32'h0000_0000);
        put_texel(63, 0, 32'h800F_55AA);
        put_texel(0, 63, 32'h0056_3412);
        put_texel(31, 17, 32'hFF01_80FF);
        // writes past the source edge are dropped
        put_texel(64, 0, 32'h1111_1111);
        put_texel(0, 64, 32'h2222_2222);
        put_texel(COORD_MAX, COORD_MAX, 32'h3333_3333);
        // reads of the corners, flipped vertically
        read_pixel(0, 63);
        read_pixel(63, 0);
        read_pixel(63, 63);
        read_pixel(0, 0);
        read_pixel(31, 46);
        // pixels outside the display read as zero and undrawn
        read_pixel(64, 0);
        read_pixel(0, 64);
        read_pixel(COORD_MAX, 0);
        read_pixel(COORD_MAX, COORD_MAX);
        run_random(150);
        settle();

        // smallest sizes everywhere, gray
        run_phase(1, 1, 1, 1, FMT_GRAY, 60);
        // largest legal sizes, alpha scaling
        run_phase(64, 64, 1024, 1024, FMT_RGBA, 190);
        // odd ratios
        run_phase(7, 5, 13, 29, FMT_GRAY, 200);

        // zero sizes act as one, oversize display as 1024, spare format as rgb,
        // then a write to an unused index that must change nothing
        write_sizes(0, 0, 2047, 2047, FMT_SPARE);
        write_register(CFG_UNUSED_INDEX, 0);
        run_random(100);
        settle();

        // oversize source acts as 64, minified vertically
        run_phase(127, 127, 100, 3, FMT_RGBA, 200);
        run_phase(3, 64, 1000, 17, FMT_RGB, 200);

        repeat (3)
            run_phase(pick_side(MAX_SOURCE_SIDE_DEF, 2**SRC_W - 1),
                      pick_side(MAX_SOURCE_SIDE_DEF, 2**SRC_W - 1),
                      pick_side(MAX_DISPLAY_SIDE_DEF, 2**DSP_W - 1),
                      pick_side(MAX_DISPLAY_SIDE_DEF, 2**DSP_W - 1),
                      FMT_W'($urandom_range(0, 3)), 130);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
